[rtl/mme_pkg.sv]
package mme_pkg;

    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int DOT_W     = 35;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic issue;
        logic first;
        logic lastk;
        logic ld_out;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic acc_done;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/mme_datapath.sv]
module mme_datapath
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [$clog2(MAX_DIM)-1:0] i_idx_i,
    input  logic [$clog2(MAX_DIM)-1:0] i_idx_j,
    input  logic [$clog2(MAX_DIM)-1:0] i_idx_l,
    input  logic [IDX_W-1:0]        i_row,
    input  logic [IDX_W-1:0]        i_col,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_out_ready,
    output t_dp_status              o_status,
    output logic                    o_out_valid,
    output logic [IDX_W-1:0]        o_out_row,
    output logic [IDX_W-1:0]        o_out_col,
    output logic signed [DOT_W-1:0] o_dot,
    output logic                    o_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [VAL_W-1:0] mem_a [DEPTH];
    logic [VAL_W-1:0] mem_b [DEPTH];

    logic              wr_in_range;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;

    logic signed [VAL_W-1:0]  r_rd_a;
    logic signed [VAL_W-1:0]  r_rd_b;
    logic                     r_rd_vld;
    logic                     r_rd_first;
    logic                     r_rd_lastk;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_mul_vld;
    logic                     r_mul_first;
    logic                     r_mul_lastk;
    logic signed [DOT_W-1:0]  r_acc;
    logic                     r_acc_done;
    logic signed [DOT_W-1:0]  prod_ext;

    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic signed [DOT_W-1:0]  r_dot;
    logic                     r_last;

    assign wr_in_range = ({1'b0, i_row} < (IDX_W+1)'(MAX_DIM)) &&
                         ({1'b0, i_col} < (IDX_W+1)'(MAX_DIM));
    assign wr_addr   = AW'(i_row) * AW'(MAX_DIM) + AW'(i_col);
    assign rd_addr_a = AW'(i_idx_i) * AW'(MAX_DIM) + AW'(i_idx_l);
    assign rd_addr_b = AW'(i_idx_l) * AW'(MAX_DIM) + AW'(i_idx_j);
    assign prod_ext  = {{(DOT_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && wr_in_range) begin
            mem_a[wr_addr] <= i_value;
        end
        if (i_cmd.wr_b && wr_in_range) begin
            mem_b[wr_addr] <= i_value;
        end
        r_rd_a <= mem_a[rd_addr_a];
        r_rd_b <= mem_b[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        r_rd_first  <= i_cmd.first;
        r_rd_lastk  <= i_cmd.lastk;
        r_prod      <= r_rd_a * r_rd_b;
        r_mul_first <= r_rd_first;
        r_mul_lastk <= r_rd_lastk;
        if (r_mul_vld) begin
            r_acc <= r_mul_first ? prod_ext : r_acc + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_mul_vld  <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.issue;
            r_mul_vld  <= r_rd_vld;
            r_acc_done <= r_mul_vld && r_mul_lastk;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_row <= IDX_W'(i_idx_i);
            r_out_col <= IDX_W'(i_idx_j);
            r_dot     <= r_acc;
            r_last    <= i_cmd.out_last;
        end
    end

    assign o_status.acc_done = r_acc_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_dot       = r_dot;
    assign o_last      = r_last;

endmodule

[rtl/mme_controller.sv]
module mme_controller
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    input  logic [FUNC_W-1:0]           i_func,
    input  t_dp_status                  i_status,
    output logic                        o_in_ready,
    output t_dp_cmd                     o_cmd,
    output logic [$clog2(MAX_DIM)-1:0]  o_idx_i,
    output logic [$clog2(MAX_DIM)-1:0]  o_idx_j,
    output logic [$clog2(MAX_DIM)-1:0]  o_idx_l
);

    localparam int DIM_W = $clog2(MAX_DIM);

    t_state             r_state, n_state;
    logic [DIM_W-1:0]   r_i, n_i;
    logic [DIM_W-1:0]   r_j, n_j;
    logic [DIM_W-1:0]   r_l, n_l;
    logic [DIM_W-1:0]   r_m_last;
    logic [DIM_W-1:0]   r_k_last;
    logic [DIM_W-1:0]   r_n_last;
    logic               accept;
    logic               elem_last;

    function automatic logic [DIM_W-1:0] last_index(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > CFG_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM - 1);
        end else begin
            res = DIM_W'(v - CFG_W'(1));
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_last <= DIM_W'(MAX_DIM - 1);
            r_k_last <= DIM_W'(MAX_DIM - 1);
            r_n_last <= DIM_W'(MAX_DIM - 1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_ROWS_A:     r_m_last <= last_index(i_cfg_data);
                CFG_INNER_SIZE: r_k_last <= last_index(i_cfg_data);
                CFG_COLS_B:     r_n_last <= last_index(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_l     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_l     <= n_l;
        end
    end

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign elem_last = (r_i == r_m_last) && (r_j == r_n_last);

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_l        = r_l;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    unique case (i_func)
                        FUNC_WR_A: o_cmd.wr_a = 1'b1;
                        FUNC_WR_B: o_cmd.wr_b = 1'b1;
                        FUNC_COMPUTE: begin
                            n_state = S_RUN;
                            n_i     = '0;
                            n_j     = '0;
                            n_l     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = (r_l == '0);
                o_cmd.lastk = (r_l == r_k_last);
                if (r_l == r_k_last) begin
                    n_l     = '0;
                    n_state = S_WAIT;
                end else begin
                    n_l = r_l + 1'b1;
                end
            end
            S_WAIT: begin
                if (i_status.acc_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.ld_out   = 1'b1;
                    o_cmd.out_last = elem_last;
                    if (elem_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RUN;
                        if (r_j == r_n_last) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idx_i = r_i;
    assign o_idx_j = r_j;
    assign o_idx_l = r_l;

endmodule

[rtl/matrix_multiply_engine.sv]
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_ready   i_func, i_row, i_col, i_value
// output    out        o_out_valid / i_out_ready o_out_row, o_out_col, o_dot, o_last
// config    in         i_cfg_wr_en               i_cfg_idx, i_cfg_data
//
// Load words write one element each. For each of the m*n result elements,
// a compute word walks the inner loop through the single read port of each store,
// then read, multiply and accumulate stages drain before the element is emitted.
// Reset is synchronous, active low; the element stores are not cleared.
// A stalled output word holds; the next element waits in the accumulator.
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [IDX_W-1:0]        i_row,
    input  logic [IDX_W-1:0]        i_col,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [IDX_W-1:0]        o_out_row,
    output logic [IDX_W-1:0]        o_out_col,
    output logic signed [DOT_W-1:0] o_dot,
    output logic                    o_last
);

    localparam int DIM_W = $clog2(MAX_DIM);

    t_dp_cmd          cmd;
    t_dp_status       status;
    logic [DIM_W-1:0] idx_i;
    logic [DIM_W-1:0] idx_j;
    logic [DIM_W-1:0] idx_l;

    mme_controller #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd),
        .o_idx_i     (idx_i),
        .o_idx_j     (idx_j),
        .o_idx_l     (idx_l)
    );

    mme_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx_i     (idx_i),
        .i_idx_j     (idx_j),
        .i_idx_l     (idx_l),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_dot       (o_dot),
        .o_last      (o_last)
    );

endmodule
